/* hw/rtl/ppsp_pkg.sv */
// Shared types and constants of the P6 stream parser.
`default_nettype none

package ppsp_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int REG_INDEX_W = 1;

    localparam logic [REG_INDEX_W-1:0] REG_MAX_DIMENSION = 1'b0;
    localparam logic [REG_INDEX_W-1:0] REG_MAX_PIXELS    = 1'b1;

    localparam logic [15:0] MAX_DIMENSION_RESET = 16'd25000;
    localparam logic [31:0] MAX_PIXELS_RESET    = 32'd100000000;

    localparam logic [7:0] CHAR_P       = 8'h50;
    localparam logic [7:0] CHAR_SIX     = 8'h36;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam logic ACTION_DATA = 1'b0;
    localparam logic ACTION_EOS  = 1'b1;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd1;
    localparam logic [2:0] KIND_SAMPLE = 3'd2;
    localparam logic [2:0] KIND_ACCEPT = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_HEADER  = 3'd1;
    localparam logic [2:0] ERR_TRUNC   = 3'd2;
    localparam logic [2:0] ERR_TRAIL   = 3'd3;
    localparam logic [2:0] ERR_LARGE   = 3'd4;
    localparam logic [2:0] ERR_OVERMAX = 3'd5;

    typedef enum logic [2:0] {
        PH_P,
        PH_SIX,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAX,
        PH_DATA,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic [15:0] max_dimension;
        logic [31:0] max_pixels;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] sample;
        logic        last_sample;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] max_value;
        logic [2:0]  error_code;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/ppsp_cfg_regs.sv */
// Configuration registers: size limits of the parser.
`default_nettype none

module ppsp_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ppsp_pkg::REG_INDEX_W-1:0]  cfg_index,
    input  logic [ppsp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ppsp_pkg::cfg_t                    cfg
);
    import ppsp_pkg::*;

    logic [15:0] max_dimension_reg;
    logic [31:0] max_pixels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dimension_reg <= MAX_DIMENSION_RESET;
            max_pixels_reg    <= MAX_PIXELS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_DIMENSION: max_dimension_reg <= cfg_data[15:0];
                REG_MAX_PIXELS:    max_pixels_reg    <= cfg_data[31:0];
                default:
                begin
                    max_dimension_reg <= max_dimension_reg;
                end
            endcase
        end
    end

    assign cfg.max_dimension = max_dimension_reg;
    assign cfg.max_pixels    = max_pixels_reg;

endmodule

`default_nettype wire

/* hw/rtl/ppsp_parser_core.sv */
// Parser state machine: header fields, sample assembly and per-byte result.
`default_nettype none

module ppsp_parser_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic                action,
    input  logic [7:0]          data_byte,
    input  ppsp_pkg::cfg_t      cfg,
    output ppsp_pkg::result_t   result
);
    import ppsp_pkg::*;

    phase_t      phase_reg, phase_step, phase_next;
    logic        sep_reg, sep_step, sep_next;
    logic        cmt_reg, cmt_step, cmt_next;
    logic        dseen_reg, dseen_step, dseen_next;
    logic [15:0] acc_reg, acc_step, acc_next;
    logic [15:0] w_reg, w_step, w_next;
    logic [15:0] h_reg, h_step, h_next;
    logic [15:0] m_reg, m_step, m_next;
    logic [33:0] left_reg, left_step, left_next;
    logic [7:0]  high_reg, high_step, high_next;
    logic        hp_reg, hp_step, hp_next;
    logic [31:0] area_reg;

    logic        is_ws, is_dig, is_hash, is_nl, is_eos;
    logic [19:0] acc_ext;
    logic        acc_ovf;
    logic        zero_field, too_large;
    logic [33:0] area3;
    logic        wide;
    logic [15:0] sample_val;
    logic        over;
    logic        sample_fire;
    logic [33:0] left_dec;
    logic        left_zero;

    assign is_eos  = (action == ACTION_EOS);
    assign is_nl   = (data_byte == CHAR_NEWLINE);
    assign is_ws   = (data_byte == CHAR_SPACE)
                     || ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));
    assign is_dig  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign is_hash = (data_byte == CHAR_HASH);

    assign acc_ext = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {16'd0, data_byte[3:0]};
    assign acc_ovf = |acc_ext[19:16];

    assign zero_field = (w_reg == 16'd0) || (h_reg == 16'd0) || (acc_reg == 16'd0);
    assign too_large  = (w_reg > cfg.max_dimension) || (h_reg > cfg.max_dimension)
                        || (area_reg > cfg.max_pixels);
    assign area3      = {2'b00, area_reg} + {1'b0, area_reg, 1'b0};

    assign wide        = |m_reg[15:8];
    assign sample_val  = wide ? {high_reg, data_byte} : {8'd0, data_byte};
    assign over        = (sample_val > m_reg);
    assign sample_fire = !wide || hp_reg;
    assign left_dec    = left_reg - 34'd1;
    assign left_zero   = (left_dec == 34'd0);

    // width and height settle at least two transfers before the header ends
    always_ff @(posedge clk)
    begin
        area_reg <= w_reg * h_reg;
    end

    always_comb
    begin : next_state
        phase_step = phase_reg;
        sep_step   = sep_reg;
        cmt_step   = cmt_reg;
        dseen_step = dseen_reg;
        acc_step   = acc_reg;
        w_step     = w_reg;
        h_step     = h_reg;
        m_step     = m_reg;
        left_step  = left_reg;
        high_step  = high_reg;
        hp_step    = hp_reg;
        if (!is_eos)
        begin
            case (phase_reg)
                PH_P:
                begin
                    phase_step = (data_byte == CHAR_P) ? PH_SIX : PH_ERROR;
                end
                PH_SIX:
                begin
                    if (data_byte == CHAR_SIX)
                    begin
                        phase_step = PH_WIDTH;
                        sep_step   = 1'b0;
                        cmt_step   = 1'b0;
                        dseen_step = 1'b0;
                        acc_step   = 16'd0;
                    end
                    else
                    begin
                        phase_step = PH_ERROR;
                    end
                end
                PH_WIDTH, PH_HEIGHT, PH_MAX:
                begin
                    if (dseen_reg)
                    begin
                        if (is_dig)
                        begin
                            acc_step = acc_ext[15:0];
                            if (acc_ovf)
                            begin
                                phase_step = PH_ERROR;
                            end
                        end
                        else if (phase_reg == PH_MAX)
                        begin
                            m_step = acc_reg;
                            if (!is_ws || zero_field || too_large)
                            begin
                                phase_step = PH_ERROR;
                            end
                            else
                            begin
                                left_step  = area3;
                                hp_step    = 1'b0;
                                phase_step = PH_DATA;
                            end
                        end
                        else
                        begin
                            if (phase_reg == PH_WIDTH)
                            begin
                                w_step = acc_reg;
                            end
                            else
                            begin
                                h_step = acc_reg;
                            end
                            dseen_step = 1'b0;
                            acc_step   = 16'd0;
                            sep_step   = 1'b1;
                            cmt_step   = is_hash;
                            if (!is_ws && !is_hash)
                            begin
                                phase_step = PH_ERROR;
                            end
                            else
                            begin
                                phase_step = (phase_reg == PH_WIDTH) ? PH_HEIGHT : PH_MAX;
                            end
                        end
                    end
                    else if (is_ws)
                    begin
                        sep_step = 1'b1;
                        if (is_nl)
                        begin
                            cmt_step = 1'b0;
                        end
                    end
                    else if (is_hash)
                    begin
                        sep_step = 1'b1;
                        cmt_step = 1'b1;
                    end
                    else if (cmt_reg)
                    begin
                        cmt_step = 1'b1;
                    end
                    else if (!sep_reg || !is_dig)
                    begin
                        phase_step = PH_ERROR;
                    end
                    else
                    begin
                        dseen_step = 1'b1;
                        acc_step   = {12'd0, data_byte[3:0]};
                    end
                end
                PH_DATA:
                begin
                    if (!sample_fire)
                    begin
                        high_step = data_byte;
                        hp_step   = 1'b1;
                    end
                    else
                    begin
                        hp_step = 1'b0;
                        if (over)
                        begin
                            phase_step = PH_ERROR;
                        end
                        else
                        begin
                            left_step = left_dec;
                            if (left_zero)
                            begin
                                phase_step = PH_DONE;
                            end
                        end
                    end
                end
                PH_DONE:
                begin
                    phase_step = PH_ERROR;
                end
                PH_ERROR:
                begin
                    phase_step = PH_ERROR;
                end
                default:
                begin
                    phase_step = PH_ERROR;
                end
            endcase
        end
    end

    // end of stream rearms the parser after its result is formed
    always_comb
    begin : rearm
        if (is_eos)
        begin
            phase_next = PH_P;
            sep_next   = 1'b0;
            cmt_next   = 1'b0;
            dseen_next = 1'b0;
            acc_next   = 16'd0;
            w_next     = 16'd0;
            h_next     = 16'd0;
            m_next     = 16'd0;
            left_next  = 34'd0;
            high_next  = 8'd0;
            hp_next    = 1'b0;
        end
        else
        begin
            phase_next = phase_step;
            sep_next   = sep_step;
            cmt_next   = cmt_step;
            dseen_next = dseen_step;
            acc_next   = acc_step;
            w_next     = w_step;
            h_next     = h_step;
            m_next     = m_step;
            left_next  = left_step;
            high_next  = high_step;
            hp_next    = hp_step;
        end
    end

    always_comb
    begin : outputs
        result.kind        = KIND_NONE;
        result.sample      = 16'd0;
        result.last_sample = 1'b0;
        result.error_code  = ERR_NONE;
        result.width       = w_step;
        result.height      = h_step;
        result.max_value   = m_step;
        if (is_eos)
        begin
            case (phase_reg)
                PH_DONE:
                begin
                    result.kind = KIND_ACCEPT;
                end
                PH_DATA:
                begin
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_TRUNC;
                end
                PH_ERROR:
                begin
                    result.kind = KIND_NONE;
                end
                default:
                begin
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_HEADER;
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_P, PH_SIX, PH_WIDTH, PH_HEIGHT:
                begin
                    if (phase_step == PH_ERROR)
                    begin
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_HEADER;
                    end
                end
                PH_MAX:
                begin
                    if (phase_step == PH_DATA)
                    begin
                        result.kind = KIND_HEADER;
                    end
                    else if (phase_step == PH_ERROR)
                    begin
                        result.kind = KIND_ERROR;
                        if (dseen_reg && !is_dig && is_ws && !zero_field && too_large)
                        begin
                            result.error_code = ERR_LARGE;
                        end
                        else
                        begin
                            result.error_code = ERR_HEADER;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (sample_fire)
                    begin
                        if (over)
                        begin
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_OVERMAX;
                        end
                        else
                        begin
                            result.kind        = KIND_SAMPLE;
                            result.sample      = sample_val;
                            result.last_sample = left_zero;
                        end
                    end
                end
                PH_DONE:
                begin
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_TRAIL;
                end
                PH_ERROR:
                begin
                    result.kind = KIND_NONE;
                end
                default:
                begin
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_P;
            sep_reg   <= 1'b0;
            cmt_reg   <= 1'b0;
            dseen_reg <= 1'b0;
            acc_reg   <= 16'd0;
            w_reg     <= 16'd0;
            h_reg     <= 16'd0;
            m_reg     <= 16'd0;
            left_reg  <= 34'd0;
            high_reg  <= 8'd0;
            hp_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            sep_reg   <= sep_next;
            cmt_reg   <= cmt_next;
            dseen_reg <= dseen_next;
            acc_reg   <= acc_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            m_reg     <= m_next;
            left_reg  <= left_next;
            high_reg  <= high_next;
            hp_reg    <= hp_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ppsp_out_reg.sv */
// Result register with valid/stall handshake toward the consumer.
`default_nettype none

module ppsp_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ppsp_pkg::result_t   result,
    input  logic                out_stall,
    output logic                out_valid,
    output logic                busy,
    output ppsp_pkg::result_t   held
);
    import ppsp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign busy = valid_reg && out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/ppm_p6_stream_parser_unit.sv */
// Top level of the P6 image byte-stream parser.
`default_nettype none

// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_stall    action, data_byte
// out      out  out_valid / out_stall  kind, sample, last_sample, width, height,
//                                      max_value, error_code
// cfg      in   cfg_write              cfg_index, cfg_data
//
// One byte per cycle unless a held result is stalled; each input transfer yields
// one result, registered in the output register in the cycle after the transfer.
// The width*height product is registered from the stored width and height registers.
// Reset clears the parser and loads the default size limits.
// in_stall rises only while a result is held and out_stall is high.

module ppm_p6_stream_parser_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [7:0]                        data_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        kind,
    output logic [15:0]                       sample,
    output logic                              last_sample,
    output logic [15:0]                       width,
    output logic [15:0]                       height,
    output logic [15:0]                       max_value,
    output logic [2:0]                        error_code,
    input  logic                              cfg_write,
    input  logic [ppsp_pkg::REG_INDEX_W-1:0]  cfg_index,
    input  logic [ppsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ppsp_pkg::*;

    cfg_t    cfg;
    result_t step_result;
    result_t held;
    logic    busy;
    logic    accept;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    ppsp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppsp_parser_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (accept),
        .action    (action),
        .data_byte (data_byte),
        .cfg       (cfg),
        .result    (step_result)
    );

    ppsp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (step_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .busy      (busy),
        .held      (held)
    );

    assign kind        = held.kind;
    assign sample      = held.sample;
    assign last_sample = held.last_sample;
    assign width       = held.width;
    assign height      = held.height;
    assign max_value   = held.max_value;
    assign error_code  = held.error_code;

    a_transfer_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("input transfer produced no result");

    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_ERROR)) |-> (error_code != ERR_NONE))
        else $error("error result without code");

    a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != KIND_ERROR)) |-> (error_code == ERR_NONE))
        else $error("error code on non-error result");

    a_last_is_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_sample) |-> (kind == KIND_SAMPLE))
        else $error("last flag on non-sample result");

endmodule

`default_nettype wire
